@@ rtl/smrg_pkg.sv @@
package smrg_pkg;

    // field widths
    localparam int ROW_W  = 16;
    localparam int COL_W  = 24;
    localparam int VAL_W  = 37;
    localparam int GD_W   = 9;
    localparam int NP_W   = 9;
    localparam int PI_W   = 8;
    localparam int FAC_W  = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    // derived widths
    localparam int NN_W     = 18;   // up to 511 * 511
    localparam int ZY_W     = 19;   // signed, +/- (n*n + n)
    localparam int ZY_N     = 9;    // dy by dz combinations
    localparam int ZY_IX_W  = 4;
    localparam int MASK_W   = 27;   // diagonal plus 26 neighbours
    localparam int SEL_W    = 5;
    localparam int NBR7     = 6;
    localparam int NBR27    = 26;

    // divider: four quotient bits per stage
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = ROW_W / DIV_STEP;

    // defaults
    localparam int DEF_MAX_GRID_DIM = 256;
    localparam int DEF_MAX_PLANES   = 256;

    localparam logic [GD_W-1:0]  GRID_DIM_RST    = GD_W'(16);
    localparam logic [NP_W-1:0]  NUM_PLANES_RST  = NP_W'(1);
    localparam logic [PI_W-1:0]  PLANE_INDEX_RST = '0;
    localparam logic             MODE_RST        = 1'b0;
    localparam logic [FAC_W-1:0] FACTOR_RST      = FAC_W'(65536);

    typedef enum logic [IDX_W-1:0] {
        CFG_GRID_DIM,
        CFG_NUM_PLANES,
        CFG_PLANE_INDEX,
        CFG_STENCIL_MODE,
        CFG_FACTOR
    } cfg_idx_t;

    typedef enum logic {
        MODE_7PT,
        MODE_27PT
    } mode_t;

    typedef enum logic [1:0] {
        DIR_NEG,
        DIR_ZERO,
        DIR_POS
    } dir_t;

    typedef struct packed {
        dir_t dx;
        dir_t dy;
        dir_t dz;
    } off_t;

    typedef struct packed {
        logic [GD_W-1:0]              n;
        logic [NP_W-1:0]              nz;
        logic [PI_W-1:0]              pz;
        mode_t                        mode;
        logic [NN_W-1:0]              nn;
        logic [COL_W-1:0]             plane_base;
        logic signed [FAC_W-1:0]      fac;
        logic signed [VAL_W-1:0]      diag_val;
        logic [ZY_N-1:0][ZY_W-1:0]    zy_off;
    } cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [GD_W-1:0]  rem;
        logic [ROW_W-1:0] quo;
    } div_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  diag_col;
        logic [MASK_W-1:0] mask;
        logic              bad;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] diag_col;
        logic [SEL_W-1:0] sel;
        logic             last;
        logic             bad;
    } pick_t;

    // neighbour j (1-based) of the chosen stencil
    function automatic off_t smrg_offset(input mode_t mode, input logic [SEL_W-1:0] j);
        off_t o;
        o = '{DIR_ZERO, DIR_ZERO, DIR_ZERO};
        if (mode == MODE_7PT)
        begin
            case (j)
                5'd1:    o = '{DIR_POS,  DIR_ZERO, DIR_ZERO};
                5'd2:    o = '{DIR_NEG,  DIR_ZERO, DIR_ZERO};
                5'd3:    o = '{DIR_ZERO, DIR_POS,  DIR_ZERO};
                5'd4:    o = '{DIR_ZERO, DIR_NEG,  DIR_ZERO};
                5'd5:    o = '{DIR_ZERO, DIR_ZERO, DIR_POS};
                5'd6:    o = '{DIR_ZERO, DIR_ZERO, DIR_NEG};
                default: o = '{DIR_ZERO, DIR_ZERO, DIR_ZERO};
            endcase
        end
        else
        begin
            case (j)
                5'd1:    o = '{DIR_NEG,  DIR_NEG,  DIR_NEG};
                5'd2:    o = '{DIR_NEG,  DIR_NEG,  DIR_ZERO};
                5'd3:    o = '{DIR_NEG,  DIR_NEG,  DIR_POS};
                5'd4:    o = '{DIR_NEG,  DIR_ZERO, DIR_NEG};
                5'd5:    o = '{DIR_NEG,  DIR_ZERO, DIR_ZERO};
                5'd6:    o = '{DIR_NEG,  DIR_ZERO, DIR_POS};
                5'd7:    o = '{DIR_NEG,  DIR_POS,  DIR_NEG};
                5'd8:    o = '{DIR_NEG,  DIR_POS,  DIR_ZERO};
                5'd9:    o = '{DIR_NEG,  DIR_POS,  DIR_POS};
                5'd10:   o = '{DIR_ZERO, DIR_NEG,  DIR_NEG};
                5'd11:   o = '{DIR_ZERO, DIR_NEG,  DIR_ZERO};
                5'd12:   o = '{DIR_ZERO, DIR_NEG,  DIR_POS};
                5'd13:   o = '{DIR_ZERO, DIR_ZERO, DIR_NEG};
                5'd14:   o = '{DIR_ZERO, DIR_ZERO, DIR_POS};
                5'd15:   o = '{DIR_ZERO, DIR_POS,  DIR_NEG};
                5'd16:   o = '{DIR_ZERO, DIR_POS,  DIR_ZERO};
                5'd17:   o = '{DIR_ZERO, DIR_POS,  DIR_POS};
                5'd18:   o = '{DIR_POS,  DIR_NEG,  DIR_NEG};
                5'd19:   o = '{DIR_POS,  DIR_NEG,  DIR_ZERO};
                5'd20:   o = '{DIR_POS,  DIR_NEG,  DIR_POS};
                5'd21:   o = '{DIR_POS,  DIR_ZERO, DIR_NEG};
                5'd22:   o = '{DIR_POS,  DIR_ZERO, DIR_ZERO};
                5'd23:   o = '{DIR_POS,  DIR_ZERO, DIR_POS};
                5'd24:   o = '{DIR_POS,  DIR_POS,  DIR_NEG};
                5'd25:   o = '{DIR_POS,  DIR_POS,  DIR_ZERO};
                5'd26:   o = '{DIR_POS,  DIR_POS,  DIR_POS};
                default: o = '{DIR_ZERO, DIR_ZERO, DIR_ZERO};
            endcase
        end
        return o;
    endfunction

    // step along one axis stays in the grid
    function automatic logic smrg_dir_ok(input dir_t d, input logic lo_ok, input logic hi_ok);
        logic ok;
        case (d)
            DIR_NEG: ok = lo_ok;
            DIR_POS: ok = hi_ok;
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

@@ rtl/stencil_matrix_row_generator.sv @@
// Stencil matrix row generator.
//
// Request channel: req_valid / req_stall with local_row. One request is one
// row of the plane owned by this block; it turns into 1 to 27 matrix entries.
// Entry channel: entry_valid / entry_stall with row, column, value, last and
// bad_row. Entries of a row leave in order, diagonal first, last set on the
// final one. A row outside the plane yields a single entry flagged bad_row.
//
// Stages: four divider stages, a check stage, the entry sequencer, the output
// register. Throughput: one entry per cycle when the receiver does not stall;
// a row has up to 7 entries in 7-point mode and 27 in 27-point mode. The
// sequencer sets that rate. Requests are taken while earlier rows are still
// in flight, as long as the stages ahead of the sequencer have room.
//
// Reset: configuration returns to its reset values and the pipeline empties.
// Configuration is to be written by the user through cfg_we / cfg_index /
// cfg_data only while idle; the block does not enforce this. When the receiver
// stalls, the output register holds its entry and the stall backs up stage by
// stage to req_stall; nothing is dropped or repeated.
module stencil_matrix_row_generator #(
    parameter int MAX_GRID_DIM = smrg_pkg::DEF_MAX_GRID_DIM,
    parameter int MAX_PLANES   = smrg_pkg::DEF_MAX_PLANES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [smrg_pkg::ROW_W-1:0]        local_row,
    input  logic                              cfg_we,
    input  logic [smrg_pkg::IDX_W-1:0]        cfg_index,
    input  logic [smrg_pkg::CFG_W-1:0]        cfg_data,
    output logic                              entry_valid,
    input  logic                              entry_stall,
    output logic [smrg_pkg::ROW_W-1:0]        row,
    output logic [smrg_pkg::COL_W-1:0]        column,
    output logic signed [smrg_pkg::VAL_W-1:0] value,
    output logic                              last,
    output logic                              bad_row
);
    import smrg_pkg::*;

    // configuration registers
    logic [GD_W-1:0]  grid_dim_reg;
    logic [NP_W-1:0]  num_planes_reg;
    logic [PI_W-1:0]  plane_index_reg;
    mode_t            mode_reg;
    logic [FAC_W-1:0] factor_reg;

    // values derived from configuration, refreshed every cycle
    logic [GD_W-1:0]           n_sat;
    logic [NP_W-1:0]           nz_sat;
    logic [2*GD_W-1:0]         nn_full;
    logic [PI_W+NN_W-1:0]      pb_full;
    logic [NN_W-1:0]           nn_reg;
    logic [COL_W-1:0]          plane_base_reg;
    logic [ZY_N-1:0][ZY_W-1:0] zy_off_reg;
    logic [ZY_N-1:0][ZY_W-1:0] zy_off_next;
    logic signed [VAL_W-1:0]   diag_val_reg;
    logic signed [VAL_W-1:0]   diag_val_next;
    cfg_t                      cfg;

    // pipeline links
    logic  div_valid [DIV_STAGES+1];
    logic  div_ready [DIV_STAGES+1];
    div_t  div_data  [DIV_STAGES+1];
    logic  item_valid;
    logic  item_ready;
    item_t item_data;
    logic  pick_valid;
    logic  pick_ready;
    pick_t pick_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_dim_reg    <= GRID_DIM_RST;
            num_planes_reg  <= NUM_PLANES_RST;
            plane_index_reg <= PLANE_INDEX_RST;
            mode_reg        <= mode_t'(MODE_RST);
            factor_reg      <= FACTOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_DIM:     grid_dim_reg    <= cfg_data[GD_W-1:0];
                CFG_NUM_PLANES:   num_planes_reg  <= cfg_data[NP_W-1:0];
                CFG_PLANE_INDEX:  plane_index_reg <= cfg_data[PI_W-1:0];
                CFG_STENCIL_MODE: mode_reg        <= mode_t'(cfg_data[0]);
                CFG_FACTOR:       factor_reg      <= cfg_data[FAC_W-1:0];
                default:          ;
            endcase
        end
    end

    // oversized dimensions clamp to the build limits
    assign n_sat  = (grid_dim_reg > MAX_GRID_DIM) ? GD_W'(MAX_GRID_DIM) : grid_dim_reg;
    assign nz_sat = (num_planes_reg > MAX_PLANES) ? NP_W'(MAX_PLANES) : num_planes_reg;

    assign nn_full = n_sat * n_sat;
    assign pb_full = plane_index_reg * nn_reg;

    // column step for each (dy, dz) pair: dz * n^2 + dy * n
    always_comb
    begin
        logic signed [ZY_W-1:0] n_s;
        logic signed [ZY_W-1:0] nn_s;
        logic signed [ZY_W-1:0] ty;
        logic signed [ZY_W-1:0] tz;
        n_s  = $signed({{(ZY_W-GD_W){1'b0}}, n_sat});
        nn_s = $signed({{(ZY_W-NN_W){1'b0}}, nn_reg});
        for (int dyc = 0; dyc < 3; dyc++)
        begin
            for (int dzc = 0; dzc < 3; dzc++)
            begin
                ty = (dyc == int'(DIR_NEG)) ? -n_s  : (dyc == int'(DIR_POS)) ? n_s  : '0;
                tz = (dzc == int'(DIR_NEG)) ? -nn_s : (dzc == int'(DIR_POS)) ? nn_s : '0;
                zy_off_next[dyc*3+dzc] = ty + tz;
            end
        end
    end

    // diagonal: -6 * factor or -26 * factor
    always_comb
    begin
        logic signed [VAL_W-1:0] f;
        logic signed [VAL_W-1:0] f6;
        f  = {{(VAL_W-FAC_W){factor_reg[FAC_W-1]}}, factor_reg};
        f6 = (f <<< 2) + (f <<< 1);
        if (mode_reg == MODE_27PT)
        begin
            diag_val_next = f6 - (f <<< 5);
        end
        else
        begin
            diag_val_next = -f6;
        end
    end

    always_ff @(posedge clk)
    begin
        nn_reg         <= nn_full[NN_W-1:0];
        plane_base_reg <= pb_full[COL_W-1:0];
        zy_off_reg     <= zy_off_next;
        diag_val_reg   <= diag_val_next;
    end

    always_comb
    begin
        cfg.n          = n_sat;
        cfg.nz         = nz_sat;
        cfg.pz         = plane_index_reg;
        cfg.mode       = mode_reg;
        cfg.nn         = nn_reg;
        cfg.plane_base = plane_base_reg;
        cfg.fac        = $signed(factor_reg);
        cfg.diag_val   = diag_val_reg;
        cfg.zy_off     = zy_off_reg;
    end

    // request enters the divider
    assign div_valid[0]     = req_valid;
    assign req_stall        = !div_ready[0];
    assign div_data[0].row  = local_row;
    assign div_data[0].rem  = '0;
    assign div_data[0].quo  = '0;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        smrg_div_stage #(
            .STAGE (s)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[s]),
            .in_ready  (div_ready[s]),
            .in_data   (div_data[s]),
            .n         (n_sat),
            .out_valid (div_valid[s+1]),
            .out_ready (div_ready[s+1]),
            .out_data  (div_data[s+1])
        );
    end

    smrg_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_ready  (div_ready[DIV_STAGES]),
        .in_data   (div_data[DIV_STAGES]),
        .cfg       (cfg),
        .out_valid (item_valid),
        .out_ready (item_ready),
        .out_data  (item_data)
    );

    smrg_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_ready  (item_ready),
        .in_data   (item_data),
        .out_valid (pick_valid),
        .out_ready (pick_ready),
        .out_data  (pick_data)
    );

    smrg_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pick_valid),
        .in_ready    (pick_ready),
        .in_data     (pick_data),
        .cfg         (cfg),
        .entry_valid (entry_valid),
        .entry_stall (entry_stall),
        .row         (row),
        .column      (column),
        .value       (value),
        .last        (last),
        .bad_row     (bad_row)
    );

endmodule

@@ rtl/smrg_div_stage.sv @@
module smrg_div_stage #(
    parameter int STAGE = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  smrg_pkg::div_t              in_data,
    input  logic [smrg_pkg::GD_W-1:0]   n,
    output logic                        out_valid,
    input  logic                        out_ready,
    output smrg_pkg::div_t              out_data
);
    import smrg_pkg::*;

    localparam int TOP_BIT = ROW_W - 1 - STAGE * DIV_STEP;

    logic  valid_reg;
    div_t  data_reg;
    div_t  data_next;

    // restoring division, one quotient bit per step
    always_comb
    begin
        logic [GD_W-1:0] r;
        logic [GD_W:0]   t;
        data_next = in_data;
        r = in_data.rem;
        for (int b = 0; b < DIV_STEP; b++)
        begin
            t = {r, in_data.row[TOP_BIT-b]};
            if (t >= {1'b0, n})
            begin
                t = t - {1'b0, n};
                data_next.quo[TOP_BIT-b] = 1'b1;
            end
            r = t[GD_W-1:0];
        end
        data_next.rem = r;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/smrg_prep.sv @@
module smrg_prep (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  smrg_pkg::div_t  in_data,
    input  smrg_pkg::cfg_t  cfg,
    output logic            out_valid,
    input  logic            out_ready,
    output smrg_pkg::item_t out_data
);
    import smrg_pkg::*;

    logic  valid_reg;
    item_t data_reg;
    item_t data_next;

    always_comb
    begin
        logic bad;
        logic x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
        off_t off;
        int   nbr;
        bad = (cfg.n == '0)
           || ({1'b0, cfg.pz} >= cfg.nz)
           || ({{(NN_W-ROW_W){1'b0}}, in_data.row} >= cfg.nn);
        // x is the remainder, y the quotient
        x_lo = (in_data.rem != '0);
        x_hi = ({1'b0, in_data.rem} + (GD_W+1)'(1)) < {1'b0, cfg.n};
        y_lo = (in_data.quo != '0);
        y_hi = ({1'b0, in_data.quo} + (ROW_W+1)'(1))
             < {{(ROW_W+1-GD_W){1'b0}}, cfg.n};
        z_lo = (cfg.pz != '0);
        z_hi = ({1'b0, cfg.pz} + NP_W'(1)) < cfg.nz;
        nbr  = (cfg.mode == MODE_27PT) ? NBR27 : NBR7;

        data_next.row      = in_data.row;
        data_next.diag_col = cfg.plane_base + {{(COL_W-ROW_W){1'b0}}, in_data.row};
        data_next.bad      = bad;
        data_next.mask     = '0;
        data_next.mask[0]  = 1'b1;
        for (int j = 1; j < MASK_W; j++)
        begin
            off = smrg_offset(cfg.mode, SEL_W'(j));
            data_next.mask[j] = !bad && (j <= nbr)
                             && smrg_dir_ok(off.dx, x_lo, x_hi)
                             && smrg_dir_ok(off.dy, y_lo, y_hi)
                             && smrg_dir_ok(off.dz, z_lo, z_hi);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/smrg_seq.sv @@
module smrg_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  smrg_pkg::item_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output smrg_pkg::pick_t out_data
);
    import smrg_pkg::*;

    logic              busy_reg;
    item_t             item_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_rest;
    logic [SEL_W-1:0]  sel;
    logic              is_last;
    logic              fire;

    // lowest pending entry goes next
    always_comb
    begin
        sel = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = SEL_W'(i);
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - MASK_W'(1));
    assign is_last   = (mask_rest == '0);
    assign fire      = busy_reg && out_ready;

    assign out_valid         = busy_reg;
    assign out_data.row      = item_reg.row;
    assign out_data.diag_col = item_reg.diag_col;
    assign out_data.sel      = sel;
    assign out_data.last     = is_last;
    assign out_data.bad      = item_reg.bad;

    assign in_ready = !busy_reg || (out_ready && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            busy_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
            mask_reg <= in_data.mask;
        end
        else if (fire)
        begin
            mask_reg <= mask_rest;
        end
    end

endmodule

@@ rtl/smrg_out.sv @@
module smrg_out (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  smrg_pkg::pick_t                   in_data,
    input  smrg_pkg::cfg_t                    cfg,
    output logic                              entry_valid,
    input  logic                              entry_stall,
    output logic [smrg_pkg::ROW_W-1:0]        row,
    output logic [smrg_pkg::COL_W-1:0]        column,
    output logic signed [smrg_pkg::VAL_W-1:0] value,
    output logic                              last,
    output logic                              bad_row
);
    import smrg_pkg::*;

    logic                    valid_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        column_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    last_reg;
    logic                    bad_row_reg;
    logic [COL_W-1:0]        column_next;
    logic signed [VAL_W-1:0] value_next;

    always_comb
    begin
        off_t                off;
        logic [ZY_IX_W-1:0]  zy_idx;
        logic [COL_W:0]      sum;
        logic [COL_W:0]      dx_term;
        logic [COL_W:0]      zy_term;
        off     = smrg_offset(cfg.mode, in_data.sel);
        zy_idx  = ZY_IX_W'(3 * int'(off.dy) + int'(off.dz));
        zy_term = {{(COL_W+1-ZY_W){cfg.zy_off[zy_idx][ZY_W-1]}}, cfg.zy_off[zy_idx]};
        case (off.dx)
            DIR_POS: dx_term = (COL_W+1)'(1);
            DIR_NEG: dx_term = '1;
            default: dx_term = '0;
        endcase
        sum = {1'b0, in_data.diag_col} + zy_term + dx_term;

        if (in_data.bad)
        begin
            column_next = '0;
            value_next  = '0;
        end
        else if (in_data.sel == '0)
        begin
            column_next = in_data.diag_col;
            value_next  = cfg.diag_val;
        end
        else
        begin
            column_next = sum[COL_W-1:0];
            value_next  = {{(VAL_W-FAC_W){cfg.fac[FAC_W-1]}}, cfg.fac};
        end
    end

    assign in_ready    = !valid_reg || !entry_stall;
    assign entry_valid = valid_reg;
    assign row         = row_reg;
    assign column      = column_reg;
    assign value       = value_reg;
    assign last        = last_reg;
    assign bad_row     = bad_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            row_reg     <= in_data.row;
            column_reg  <= column_next;
            value_reg   <= value_next;
            last_reg    <= in_data.last;
            bad_row_reg <= in_data.bad;
        end
    end

endmodule

@@ rtl/smrg_checker.sv @@
module smrg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              entry_valid,
    input logic                              entry_stall,
    input logic [smrg_pkg::ROW_W-1:0]        row,
    input logic [smrg_pkg::COL_W-1:0]        column,
    input logic signed [smrg_pkg::VAL_W-1:0] value,
    input logic                              last,
    input logic                              bad_row
);

    // stalled entry holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && entry_stall |=> entry_valid && $stable(row) && $stable(column)
            && $stable(value) && $stable(last) && $stable(bad_row))
        else $error("stalled entry changed");

    // a bad request is a single empty entry
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && bad_row |-> last && column == '0 && value == '0)
        else $error("bad row entry malformed");

    // entries of one row follow without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && !entry_stall && !last |=> entry_valid)
        else $error("gap inside a row");

    // all entries of one row carry the same row
    a_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && !entry_stall && !last |=> row == $past(row) && !bad_row)
        else $error("row changed before last entry");

endmodule

bind stencil_matrix_row_generator smrg_checker u_smrg_checker (.*);
